FILE: hdl/tcw_pkg.sv
// Package with the shared constants, types and helpers of the text console writer.
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = ROWS * COLUMNS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int COPY_LAST = (ROWS - 1) * COLUMNS - 1;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'h0A;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_FLUSH,
    ST_BLANK,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic copy;
    logic clear;
    logic blank;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic will_scroll;
    logic cnt_last_copy;
    logic cnt_last_all;
    logic out_free;
  } tcw_sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

FILE: hdl/tcw_ctrl.sv
// Controller state machine of the text console writer.
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  tcw_state_t state_r;
  tcw_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.cnt_last_all) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = sts.will_scroll ? ST_COPY : ST_DONE;
      ST_COPY:  if (sts.cnt_last_copy) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_BLANK;
      ST_BLANK: if (sts.cnt_last_all) state_nxt = ST_DONE;
      ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_EXEC:  cmd.exec = 1'b1;
      ST_COPY:  cmd.copy = 1'b1;
      ST_FLUSH: cmd = '0;
      ST_BLANK: cmd.blank = 1'b1;
      ST_DONE:  cmd.load_out = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

FILE: hdl/tcw_datapath.sv
// Datapath of the text console writer: cell store, cursor, color and result register.
module tcw_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcw_pkg::tcw_cmd_t                 cmd,
  output tcw_pkg::tcw_sts_t                 sts,
  input  logic [tcw_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tuser,
  input  logic                              cfg_wr_en,
  input  logic [7:0]                        cfg_wr_data,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [tcw_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import tcw_pkg::*;

  logic [15:0] mem [CELLS];

  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [7:0]        color_r;
  logic [ADDR_W-1:0] cnt_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic              cp_v_r;
  logic [15:0]       rd_data_r;
  logic              act_r;
  logic [7:0]        ch_r;
  logic [4:0]        rrow_r;
  logic [6:0]        rcol_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic              at_last_row;
  logic              at_last_col;
  logic              in_range;
  logic              put_char;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic [15:0]       cell_out;
  logic [ADDR_W-1:0] pos;

  assign at_last_row = (32'(row_r) == ROWS - 1);
  assign at_last_col = (32'(col_r) == COLUMNS - 1);
  assign in_range    = (32'(rrow_r) < ROWS) && (32'(rcol_r) < COLUMNS);
  assign put_char    = (ch_r != CH_NEWLINE) && (ch_r != CH_BACKSPACE);
  assign cur_addr    = cell_addr(row_r, col_r);

  assign sts.will_scroll   = (act_r == ACT_PUT) && at_last_row &&
                             ((ch_r == CH_NEWLINE) || (put_char && at_last_col));
  assign sts.cnt_last_copy = (32'(cnt_r) == COPY_LAST);
  assign sts.cnt_last_all  = (32'(cnt_r) == CELLS - 1);
  assign sts.out_free      = !out_valid_r || out_tready;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cell_addr(ROW_W'(rrow_r), COL_W'(rcol_r));
    if (cmd.copy) begin
      rd_en   = 1'b1;
      rd_addr = cnt_r + ADDR_W'(COLUMNS);
    end else if (cmd.exec && (act_r == ACT_READ) && in_range) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_r;
    wdata = {RESET_COLOR, CH_SPACE};
    priority if (cp_v_r) begin
      we    = 1'b1;
      waddr = wr_addr_r;
      wdata = rd_data_r;
    end else if (cmd.clear) begin
      we = 1'b1;
    end else if (cmd.blank) begin
      we    = 1'b1;
      wdata = {color_r, CH_SPACE};
    end else if (cmd.exec && (act_r == ACT_PUT)) begin
      if (ch_r == CH_BACKSPACE) begin
        we    = (col_r != '0);
        waddr = cur_addr - ADDR_W'(1);
        wdata = {color_r, CH_SPACE};
      end else if (put_char) begin
        we    = 1'b1;
        waddr = cur_addr;
        wdata = {color_r, ch_r};
      end
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r  <= in_tuser;
      ch_r   <= in_tdata[7:0];
      rrow_r <= in_tdata[12:8];
      rcol_r <= in_tdata[19:13];
    end
    wr_addr_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      cp_v_r <= 1'b0;
    end else begin
      cp_v_r <= cmd.copy;
      if (cmd.exec) begin
        cnt_r <= '0;
      end else if (cmd.clear || cmd.copy || cmd.blank) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= RESET_COLOR;
    end else if (cfg_wr_en) begin
      color_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.exec && (act_r == ACT_PUT)) begin
      if (ch_r == CH_NEWLINE) begin
        col_r <= '0;
        if (!at_last_row) row_r <= row_r + ROW_W'(1);
      end else if (ch_r == CH_BACKSPACE) begin
        if (col_r != '0) col_r <= col_r - COL_W'(1);
      end else if (at_last_col) begin
        col_r <= '0;
        if (!at_last_row) row_r <= row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  assign pos      = cur_addr;
  assign cell_out = ((act_r == ACT_READ) && in_range) ? rd_data_r : 16'h0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {1'b0, cell_out, 11'(pos), 7'(col_r), 5'(row_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hdl/text_console_writer_top.sv
// Top level of the text console writer: controller, datapath and assertions.
//
// A character-cell console with an 80x25 store of 16-bit cells (character in
// the low byte, attribute in the high byte) and a cursor. After reset the block
// clears the store to spaces in attribute 0x0A, one cell per cycle; in_tready
// stays low until then. A read or a put that does not scroll goes from transfer
// to result through accept, one store access and the result load, which waits
// for a free output register. A put that scrolls walks the store through its
// single write port, one cell per cycle, in 1920 copies, one flush and 80
// blanks. The next item is taken while the last result waits in the output
// register.
module text_console_writer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], read_row[12:8], read_column[19:13], zero
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // cursor_row[4:0], cursor_column[11:5],
                                  // cursor_position[22:12], cell_data[38:23], zero
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while holding a result");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transfer taken while an item is in progress");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((32'(out_tdata[4:0]) < ROWS) && (32'(out_tdata[11:5]) < COLUMNS)))
    else $error("reported cursor outside the screen");
`endif

endmodule

FILE: verif/tb_text_console_writer_top.sv
// Self-checking testbench for the text console writer: puts, reads, scrolls and color changes.
`timescale 1ns / 1ps

module tb_text_console_writer_top;
  import tcw_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
  } cursor_report_t;

  // The class mirrors the store, the cursor and the text color.
  class console_shadow;
    logic [15:0]    grid [CELLS];
    int unsigned    row_now;
    int unsigned    col_now;
    logic [7:0]     color;
    cursor_report_t waiting [$];
    int unsigned    n_errors;

    function new();
      row_now = 0;
      col_now = 0;
      color = RESET_COLOR;
      n_errors = 0;
      foreach (grid[i]) grid[i] = {RESET_COLOR, CH_SPACE};
    endfunction

    function int pending();
      return waiting.size();
    endfunction

    function void flag(string what);
      n_errors++;
      if (n_errors <= 10) $display("mismatch: %s", what);
    endfunction

    function void step_down();
      row_now++;
      if (row_now >= ROWS) begin
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) grid[i] = grid[i + COLUMNS];
        for (int i = 0; i < COLUMNS; i++) grid[(ROWS - 1) * COLUMNS + i] = {color, CH_SPACE};
        row_now = ROWS - 1;
      end
    endfunction

    function void take_item(logic act, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
      cursor_report_t exp;
      logic [15:0]    data;
      data = '0;
      if (act == ACT_READ) begin
        if (rr < ROWS && rc < COLUMNS) data = grid[int'(rr) * COLUMNS + int'(rc)];
      end else if (ch == CH_NEWLINE) begin
        col_now = 0;
        step_down();
      end else if (ch == CH_BACKSPACE) begin
        if (col_now > 0) begin
          col_now--;
          grid[row_now * COLUMNS + col_now] = {color, CH_SPACE};
        end
      end else begin
        grid[row_now * COLUMNS + col_now] = {color, ch};
        col_now++;
        if (col_now >= COLUMNS) begin
          col_now = 0;
          step_down();
        end
      end
      exp.cursor_row = row_now[4:0];
      exp.cursor_column = col_now[6:0];
      exp.cursor_position = 11'(row_now * COLUMNS + col_now);
      exp.cell_data = data;
      waiting.push_back(exp);
    endfunction

    function void check_result(logic [39:0] word);
      cursor_report_t got;
      cursor_report_t exp;
      got.cursor_row = word[4:0];
      got.cursor_column = word[11:5];
      got.cursor_position = word[22:12];
      got.cell_data = word[38:23];
      if (waiting.size() == 0) begin
        flag($sformatf("result with nothing expected: row %0d col %0d pos %0d cell %h",
                       got.cursor_row, got.cursor_column, got.cursor_position, got.cell_data));
        return;
      end
      exp = waiting.pop_front();
      if (got !== exp)
        flag($sformatf({"expected row %0d col %0d pos %0d cell %h, ",
                        "got row %0d col %0d pos %0d cell %h"},
                       exp.cursor_row, exp.cursor_column, exp.cursor_position, exp.cell_data,
                       got.cursor_row, got.cursor_column, got.cursor_position, got.cell_data));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;  // char_code[7:0], read_row[12:8], read_column[19:13], zero
  logic        in_tuser = 1'b0;  // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;  // cursor_row[4:0], cursor_column[11:5],
                           // cursor_position[22:12], cell_data[38:23], zero
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  console_shadow shadow = new();
  bit            calm = 1'b0;
  int            stall_left = 0;
  int            idle_cycles = 0;

  text_console_writer_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 12);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic act, input logic [7:0] ch,
                           input logic [4:0] rr, input logic [6:0] rc);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {4'b0, rc, rr, ch};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    shadow.take_item(act, ch, rr, rc);
  endtask

  task automatic send_put(input logic [7:0] ch);
    send_item(ACT_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  task automatic send_read(input logic [4:0] rr, input logic [6:0] rc);
    send_item(ACT_READ, 8'($urandom_range(0, 255)), rr, rc);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      if ($urandom_range(0, 7) == 0)
        send_read(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
      else
        send_read(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
    end else if (pick < 38) begin
      send_put(CH_NEWLINE);
    end else if (pick < 46) begin
      send_put(CH_BACKSPACE);
    end else begin
      send_put(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic write_color(input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow.color = value;
  endtask

  initial begin
    logic [7:0] palette [5];
    palette = '{8'h00, 8'hFF, 8'h00, 8'h00, RESET_COLOR};
    palette[2] = 8'($urandom_range(0, 255));
    palette[3] = 8'($urandom_range(0, 255));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Backspace at the home position must leave everything as it is.
    send_put(CH_BACKSPACE);
    send_read(5'd0, 7'd0);
    send_read(5'(ROWS - 1), 7'(COLUMNS - 1));
    send_read(5'(ROWS), 7'd0);
    send_read(5'd0, 7'(COLUMNS));
    send_read(5'd31, 7'd127);
    send_put(8'h00);
    send_put(8'hFF);
    send_put(8'h41);
    send_put(CH_BACKSPACE);
    send_read(5'd0, 7'd0);
    send_read(5'd0, 7'd1);
    send_read(5'd0, 7'd2);
    send_put(CH_NEWLINE);
    send_put(8'h7F);
    send_read(5'd1, 7'd0);
    send_put(CH_NEWLINE);
    send_put(CH_NEWLINE);
    send_read(5'd3, 7'd0);

    for (int p = 0; p < 5; p++) begin
      drain();
      write_color(palette[p]);
      calm = (p == 4);
      repeat (160) random_item();
    end

    drain();
    repeat (20) @(posedge clk);
    if (shadow.n_errors == 0 && shadow.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/tcw_pkg.sv
hdl/tcw_ctrl.sv
hdl/tcw_datapath.sv
hdl/text_console_writer_top.sv
verif/tb_text_console_writer_top.sv
